[src/rle_mb_pkg.sv]
// Package for the multibyte run-length encoder: result record type,
// field widths and fixed constants. No dependencies.
package rle_mb_pkg;

  localparam int unsigned SYM_W      = 64;
  localparam int unsigned SYM_BYTES  = SYM_W / 8;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned TAIL_W     = 3;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic {
    KIND_RUN  = 1'b0,
    KIND_TAIL = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [LEN_W-1:0]  run_len;
    logic [SYM_W-1:0]  sym;
    logic [TAIL_W-1:0] tail_cnt;
    logic              last;
  } result_t;

endpackage

[src/rle_mb_if.sv]
// Valid/ready channel interfaces for the multibyte run-length encoder.
// Depends on rle_mb_pkg for the field widths.
interface rle_mb_in_if import rle_mb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface rle_mb_out_if import rle_mb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              item_kind;
  logic [LEN_W-1:0]  run_length;
  logic [SYM_W-1:0]  symbol_value;
  logic [TAIL_W-1:0] tail_count;
  logic              stream_end;

  modport source (output valid, output item_kind, output run_length, output symbol_value,
                  output tail_count, output stream_end, input ready);
  modport sink   (input valid, input item_kind, input run_length, input symbol_value,
                  input tail_count, input stream_end, output ready);
endinterface

[src/run_length_encoder_multibyte.sv]
// Top level of the multibyte run-length encoder: symbol assembly, run
// counting and a small result queue. Depends on rle_mb_pkg and rle_mb_if.sv.
// The results of an accepted input item are written into the result queue, whose head drives the output.
// Throughput: one input item per cycle while each item makes at most one result and
// out_chan.ready stays high; an item that makes two results pushes both into the
// four-entry result queue, whose fill level alone sets in_chan.ready.
// Reset (rst_n low, synchronous): symbol size returns to one byte, stream state and queue clear.
module run_length_encoder_multibyte
  import rle_mb_pkg::*;
#(
  parameter int unsigned MAX_SYMBOL_BYTES = 8,
  parameter int unsigned RUN_LIMIT        = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  rle_mb_in_if.sink         in_chan,
  rle_mb_out_if.source      out_chan,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  localparam logic [SIZE_W-1:0] MaxSize  = SIZE_W'(MAX_SYMBOL_BYTES);
  localparam logic [LEN_W-1:0]  RunLimit = LEN_W'(RUN_LIMIT);

  // Configuration and stream state.
  logic [SIZE_W-1:0] size_cfg_r;
  logic [SYM_W-1:0]  asm_sym_r,  asm_sym_nxt;
  logic [SIZE_W-1:0] asm_cnt_r,  asm_cnt_nxt;
  logic [SYM_W-1:0]  run_sym_r,  run_sym_nxt;
  logic              run_open_r, run_open_nxt;
  logic [LEN_W-1:0]  run_cnt_r,  run_cnt_nxt;

  // Result queue.
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     fill_r, fill_nxt;

  logic        in_acc, out_acc;
  logic [SIZE_W-1:0] size_eff;
  logic [1:0]  n_push;
  result_t     res0, res1;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // Out-of-range sizes are clamped: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (size_cfg_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_cfg_r > MaxSize) begin
      size_eff = MaxSize;
    end else begin
      size_eff = size_cfg_r;
    end
  end

  // One pass over the accepted byte: place it in the assembling symbol, and when the
  // symbol completes either extend the open run or close it and open a new one.
  // The final byte then flushes the run and any partial symbol as a tail.
  always_comb begin
    logic [SIZE_W-1:0] cnt0;
    logic [SIZE_W-1:0] cnt1;
    logic [SYM_W-1:0]  asm1;
    logic [LEN_W:0]    inc;
    result_t           r;

    asm_sym_nxt  = asm_sym_r;
    asm_cnt_nxt  = asm_cnt_r;
    run_sym_nxt  = run_sym_r;
    run_open_nxt = run_open_r;
    run_cnt_nxt  = run_cnt_r;
    n_push       = 2'd0;
    res0         = '0;
    res1         = '0;
    r            = '0;

    cnt0 = (asm_cnt_r >= size_eff) ? '0 : asm_cnt_r;
    asm1 = asm_sym_r;
    for (int i = 0; i < SYM_BYTES; i++) begin
      if (cnt0[TAIL_W-1:0] == TAIL_W'(i)) begin
        asm1[8*i +: 8] = asm_sym_r[8*i +: 8] | in_chan.data_byte;
      end
    end
    cnt1 = cnt0 + SIZE_W'(1);
    inc  = {1'b0, run_cnt_r} + (LEN_W+1)'(1);

    if (in_acc) begin
      asm_sym_nxt = asm1;
      asm_cnt_nxt = cnt1;

      if (cnt1 == size_eff) begin
        asm_sym_nxt = '0;
        asm_cnt_nxt = '0;
        if (run_open_r && asm1 == run_sym_r) begin
          // Same symbol: count it, and split the run once it hits the limit.
          if (inc >= {1'b0, RunLimit}) begin
            r.kind    = KIND_RUN;
            r.run_len = inc[LEN_W-1:0];
            r.sym     = run_sym_r;
            res0      = r;
            n_push    = 2'd1;
            run_cnt_nxt = '0;
          end else begin
            run_cnt_nxt = inc[LEN_W-1:0];
          end
        end else begin
          // New symbol: close the previous run unless a split just emptied it.
          if (run_open_r && run_cnt_r != '0) begin
            r.kind    = KIND_RUN;
            r.run_len = run_cnt_r;
            r.sym     = run_sym_r;
            res0      = r;
            n_push    = 2'd1;
          end
          run_sym_nxt  = asm1;
          run_open_nxt = 1'b1;
          run_cnt_nxt  = LEN_W'(1);
        end
      end

      if (in_chan.final_byte) begin
        if (run_open_nxt && run_cnt_nxt != '0) begin
          r          = '0;
          r.kind     = KIND_RUN;
          r.run_len  = run_cnt_nxt;
          r.sym      = run_sym_nxt;
          if (n_push == 2'd0) begin
            res0 = r;
          end else begin
            res1 = r;
          end
          n_push = n_push + 2'd1;
        end
        if (asm_cnt_nxt != '0) begin
          r          = '0;
          r.kind     = KIND_TAIL;
          r.sym      = asm_sym_nxt;
          r.tail_cnt = asm_cnt_nxt[TAIL_W-1:0];
          if (n_push == 2'd0) begin
            res0 = r;
          end else begin
            res1 = r;
          end
          n_push = n_push + 2'd1;
        end
        // The last result of the final byte closes the stream.
        if (n_push == 2'd1) begin
          res0.last = 1'b1;
        end else if (n_push == 2'd2) begin
          res1.last = 1'b1;
        end
        asm_sym_nxt  = '0;
        asm_cnt_nxt  = '0;
        run_sym_nxt  = '0;
        run_open_nxt = 1'b0;
        run_cnt_nxt  = '0;
      end
    end
  end

  // A configuration write clears the stream and takes priority over the byte path's state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= SIZE_W'(1);
      asm_sym_r  <= '0;
      asm_cnt_r  <= '0;
      run_sym_r  <= '0;
      run_open_r <= 1'b0;
      run_cnt_r  <= '0;
    end else if (cfg_we) begin
      size_cfg_r <= cfg_wdata;
      asm_sym_r  <= '0;
      asm_cnt_r  <= '0;
      run_sym_r  <= '0;
      run_open_r <= 1'b0;
      run_cnt_r  <= '0;
    end else begin
      asm_sym_r  <= asm_sym_nxt;
      asm_cnt_r  <= asm_cnt_nxt;
      run_sym_r  <= run_sym_nxt;
      run_open_r <= run_open_nxt;
      run_cnt_r  <= run_cnt_nxt;
    end
  end

  // The queue keeps room for two results whenever a byte may be accepted.
  assign in_chan.ready = (fill_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    fill_nxt = fill_r + (FIFO_AW+1)'(n_push);
    if (out_acc) begin
      fill_nxt = fill_nxt - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(n_push);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  assign out_chan.valid        = (fill_r != '0);
  assign out_chan.item_kind    = fifo_r[rd_ptr_r].kind;
  assign out_chan.run_length   = fifo_r[rd_ptr_r].run_len;
  assign out_chan.symbol_value = fifo_r[rd_ptr_r].sym;
  assign out_chan.tail_count   = fifo_r[rd_ptr_r].tail_cnt;
  assign out_chan.stream_end   = fifo_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  // The queue never holds more results than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // The final byte of a stream always produces at least one result.
  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.final_byte) |-> (n_push != 2'd0))
    else $error("final byte produced no result");

  // After the final byte the stream state is back to empty.
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.final_byte) |=> (asm_cnt_r == '0 && !run_open_r && run_cnt_r == '0))
    else $error("stream state not cleared after final byte");

  // The run counter is split before it can reach the limit.
  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    run_cnt_r < RunLimit)
    else $error("run counter reached the limit");
`endif

endmodule
